// ===== rtl/lzwc_pkg.sv =====
`default_nettype none

package lzwc_pkg;

   // Printable alphabet handled by the compressor.
   localparam logic [7:0] FIRST_CHAR = 8'd32;
   localparam logic [7:0] LAST_CHAR  = 8'd122;

   // Number of implicit single-character codes.
   localparam int BASE_CODES = 91;

   // Character index width (c - FIRST_CHAR) and output code width.
   localparam int CH_W       = 7;
   localparam int CODE_OUT_W = 9;

   // Message tag stored with every hash slot; zero marks a cleared slot.
   localparam int EPOCH_W = 4;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [CODE_OUT_W-1:0] code;
      logic                  last_res;
      logic                  error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/lzw_text_compressor_core.sv =====
`default_nettype none

// Channel   Direction  Payload                          Accepted when
// -------   ---------  -------------------------------  -----------------------
// req_      in         character[7:0], last             req_valid && req_ready
// rsp_      out        code[8:0], last_res, error       rsp_valid && rsp_ready
//
// A request that extends a match is accepted in ST_IDLE, then probes the
// dictionary RAM in ST_PROBE, one slot per probe via its single read port,
// then pushes each owed response into the two-entry response queue.
// A request that only starts a match leaves the engine in ST_IDLE.
// After reset, and after every fifteenth message, a clearing pass writes every
// slot of the 2**(clog2(DICT_SIZE)+1)-entry RAM, one slot a cycle, with
// req_ready low. A full response queue stalls the engine in its push states.
module lzw_text_compressor_core #(
   parameter int DICT_SIZE = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lzwc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lzwc_pkg::rsp_type      rsp_data
);

   localparam int CODE_W  = $clog2(DICT_SIZE);
   localparam int CNT_W   = CODE_W + 1;
   localparam int HASH_W  = CODE_W + 1;
   localparam int CH_W    = lzwc_pkg::CH_W;
   localparam int EPOCH_W = lzwc_pkg::EPOCH_W;
   localparam int OUT_W   = lzwc_pkg::CODE_OUT_W;
   localparam int SLOT_W  = EPOCH_W + CODE_W + CH_W + CODE_W;

   // The dictionary lives in an open-addressed hash table with linear probing.
   // Each slot holds {epoch, prefix code, character, entry code}. A slot counts
   // as occupied only when its epoch equals the current message epoch, so the
   // end of a message empties the table by bumping the epoch. The table has at
   // least twice as many slots as entries, which keeps every probe chain short
   // and guarantees an empty slot ends it.

   lzwc_pkg::state_type state_ff, state_in;

   logic [CH_W-1:0]    char_ff, char_in;
   logic               last_ff, last_in;
   logic [CODE_W-1:0]  match_ff, match_in;
   logic               active_ff, active_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               wrap_ff, wrap_in;
   logic [HASH_W-1:0]  probe_addr_ff, probe_addr_in;
   logic [HASH_W-1:0]  clr_addr_ff, clr_addr_in;
   lzwc_pkg::rsp_type  res_a_ff, res_a_in;
   lzwc_pkg::rsp_type  res_b_ff, res_b_in;
   logic               two_ff, two_in;

   logic               req_fire;
   logic               in_bad;
   logic [CH_W-1:0]    ch_in;
   logic               dict_reset;

   logic               mem_rd_en;
   logic [HASH_W-1:0]  mem_rd_addr;
   logic [SLOT_W-1:0]  mem_rd_data;
   logic               mem_wr_en;
   logic [HASH_W-1:0]  mem_wr_addr;
   logic [SLOT_W-1:0]  mem_wr_data;

   logic [EPOCH_W-1:0] slot_epoch;
   logic [CODE_W-1:0]  slot_prefix;
   logic [CH_W-1:0]    slot_char;
   logic [CODE_W-1:0]  slot_code;
   logic               slot_valid;
   logic               slot_hit;

   logic               q_push;
   lzwc_pkg::rsp_type  q_push_data;
   logic               q_full;

   // Home slot of a (prefix, character) pair: the character lands in the top
   // bits so that pairs sharing a prefix spread across the table.
   function automatic logic [HASH_W-1:0] hash_f(input logic [CODE_W-1:0] prefix,
                                                input logic [CH_W-1:0]   ch);
      logic [HASH_W-1:0] hp;
      logic [HASH_W-1:0] hc;
      hp = HASH_W'(prefix);
      hc = HASH_W'(ch) << (HASH_W - CH_W);
      hash_f = hp ^ hc;
   endfunction

   // Emitted codes are the dictionary index plus one, cut to the port width.
   function automatic logic [OUT_W-1:0] code_out_f(input logic [CODE_W-1:0] c);
      logic [CODE_W:0] s;
      s = {1'b0, c} + 1'b1;
      code_out_f = OUT_W'(s);
   endfunction

   assign req_ready = (state_ff == lzwc_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_bad    = (req_data.character < lzwc_pkg::FIRST_CHAR) ||
                      (req_data.character > lzwc_pkg::LAST_CHAR);
   assign ch_in     = CH_W'(req_data.character - lzwc_pkg::FIRST_CHAR);

   assign slot_epoch  = mem_rd_data[SLOT_W-1 -: EPOCH_W];
   assign slot_prefix = mem_rd_data[CODE_W+CH_W+CODE_W-1 -: CODE_W];
   assign slot_char   = mem_rd_data[CH_W+CODE_W-1 -: CH_W];
   assign slot_code   = mem_rd_data[CODE_W-1:0];
   assign slot_valid  = (slot_epoch == epoch_ff);
   assign slot_hit    = slot_valid && (slot_prefix == match_ff) && (slot_char == char_ff);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = lzwc_pkg::ST_IDLE;
            end
         end
         lzwc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (in_bad || (!active_ff && req_data.last)) begin
                  state_in = lzwc_pkg::ST_EMIT_A;
               end else if (active_ff) begin
                  state_in = lzwc_pkg::ST_PROBE;
               end
            end
         end
         lzwc_pkg::ST_PROBE: begin
            if (slot_hit) begin
               state_in = last_ff ? lzwc_pkg::ST_EMIT_A : lzwc_pkg::ST_IDLE;
            end else if (!slot_valid) begin
               state_in = lzwc_pkg::ST_EMIT_A;
            end
         end
         lzwc_pkg::ST_EMIT_A: begin
            if (!q_full) begin
               if (two_ff) begin
                  state_in = lzwc_pkg::ST_EMIT_B;
               end else if (wrap_ff) begin
                  state_in = lzwc_pkg::ST_CLEAR;
               end else begin
                  state_in = lzwc_pkg::ST_IDLE;
               end
            end
         end
         lzwc_pkg::ST_EMIT_B: begin
            if (!q_full) begin
               state_in = wrap_ff ? lzwc_pkg::ST_CLEAR : lzwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lzwc_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      char_in       = char_ff;
      last_in       = last_ff;
      match_in      = match_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      epoch_in      = epoch_ff;
      wrap_in       = wrap_ff;
      probe_addr_in = probe_addr_ff;
      clr_addr_in   = clr_addr_ff;
      res_a_in      = res_a_ff;
      res_b_in      = res_b_ff;
      two_in        = two_ff;
      dict_reset    = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = probe_addr_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = probe_addr_ff;
      mem_wr_data   = {epoch_ff, match_ff, char_ff, count_ff[CODE_W-1:0]};
      q_push        = 1'b0;
      q_push_data   = res_a_ff;

      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            // Epoch zero is never current, so a zeroed slot reads as empty.
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               wrap_in = 1'b0;
            end
         end
         lzwc_pkg::ST_IDLE: begin
            if (req_fire) begin
               char_in = ch_in;
               last_in = req_data.last;
               two_in  = 1'b0;
               if (in_bad) begin
                  // The character is dropped; only a final request touches state.
                  res_a_in.code     = '0;
                  res_a_in.last_res = req_data.last && !active_ff;
                  res_a_in.error    = 1'b1;
                  two_in            = req_data.last && active_ff;
                  res_b_in.code     = code_out_f(match_ff);
                  res_b_in.last_res = 1'b1;
                  res_b_in.error    = 1'b0;
                  dict_reset        = req_data.last;
               end else if (!active_ff) begin
                  match_in  = CODE_W'(ch_in);
                  active_in = 1'b1;
                  if (req_data.last) begin
                     res_a_in.code     = code_out_f(CODE_W'(ch_in));
                     res_a_in.last_res = 1'b1;
                     res_a_in.error    = 1'b0;
                     dict_reset        = 1'b1;
                  end
               end else begin
                  mem_rd_en     = 1'b1;
                  mem_rd_addr   = hash_f(match_ff, ch_in);
                  probe_addr_in = hash_f(match_ff, ch_in);
               end
            end
         end
         lzwc_pkg::ST_PROBE: begin
            if (slot_hit) begin
               match_in = slot_code;
               if (last_ff) begin
                  res_a_in.code     = code_out_f(slot_code);
                  res_a_in.last_res = 1'b1;
                  res_a_in.error    = 1'b0;
                  dict_reset        = 1'b1;
               end
            end else if (slot_valid) begin
               // Occupied by another pair: step to the next slot.
               mem_rd_en     = 1'b1;
               mem_rd_addr   = probe_addr_ff + 1'b1;
               probe_addr_in = probe_addr_ff + 1'b1;
            end else begin
               // Pair not in the dictionary: emit the match and add the pair
               // in this empty slot while the dictionary has room.
               res_a_in.code     = code_out_f(match_ff);
               res_a_in.last_res = 1'b0;
               res_a_in.error    = 1'b0;
               if (count_ff < CNT_W'(DICT_SIZE)) begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
               match_in = CODE_W'(char_ff);
               if (last_ff) begin
                  two_in            = 1'b1;
                  res_b_in.code     = code_out_f(CODE_W'(char_ff));
                  res_b_in.last_res = 1'b1;
                  res_b_in.error    = 1'b0;
                  dict_reset        = 1'b1;
               end
            end
         end
         lzwc_pkg::ST_EMIT_A: begin
            q_push      = 1'b1;
            q_push_data = res_a_ff;
         end
         lzwc_pkg::ST_EMIT_B: begin
            q_push      = 1'b1;
            q_push_data = res_b_ff;
         end
         default: begin
         end
      endcase

      // End of message: empty the dictionary by moving to a fresh epoch. When
      // the epoch counter runs out, the table is swept before the next request.
      if (dict_reset) begin
         count_in  = CNT_W'(lzwc_pkg::BASE_CODES);
         match_in  = '0;
         active_in = 1'b0;
         if (epoch_ff == '1) begin
            epoch_in = EPOCH_W'(1);
            wrap_in  = 1'b1;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lzwc_pkg::ST_CLEAR;
         match_ff    <= '0;
         active_ff   <= 1'b0;
         count_ff    <= CNT_W'(lzwc_pkg::BASE_CODES);
         epoch_ff    <= EPOCH_W'(1);
         wrap_ff     <= 1'b0;
         clr_addr_ff <= '0;
         two_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         match_ff    <= match_in;
         active_ff   <= active_in;
         count_ff    <= count_in;
         epoch_ff    <= epoch_in;
         wrap_ff     <= wrap_in;
         clr_addr_ff <= clr_addr_in;
         two_ff      <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      last_ff       <= last_in;
      probe_addr_ff <= probe_addr_in;
      res_a_ff      <= res_a_in;
      res_b_ff      <= res_b_in;
   end

   lzwc_dict_mem #(
      .ADDR_W (HASH_W),
      .DATA_W (SLOT_W)
   ) u_dict_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   lzwc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(lzwc_pkg::BASE_CODES)) && (count_ff <= CNT_W'(DICT_SIZE)))
      else $error("dictionary entry count out of range");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("current epoch collides with the cleared-slot mark");

   a_probe_needs_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzwc_pkg::ST_PROBE) |-> active_ff)
      else $error("dictionary probe without a pending match");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
      else $error("read and write of the same slot in one cycle");

   a_final_hit_resets: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzwc_pkg::ST_PROBE && slot_hit && last_ff) |=>
      (count_ff == CNT_W'(lzwc_pkg::BASE_CODES) && !active_ff))
      else $error("dictionary not reset after the final request");
`endif

endmodule

`default_nettype wire

// ===== rtl/lzwc_dict_mem.sv =====
`default_nettype none

// Single-port-write, single-port-read synchronous RAM with a registered read.
module lzwc_dict_mem #(
   parameter int ADDR_W = 9,
   parameter int DATA_W = 27
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lzwc_rsp_queue.sv =====
`default_nettype none

// Two-entry response queue that decouples the dictionary engine from the
// response channel.
module lzwc_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire lzwc_pkg::rsp_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lzwc_pkg::rsp_type      rsp_data
);

   lzwc_pkg::rsp_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;

   // The block is built with its default dictionary size, and the reference
   // dictionary in this bench mirrors that size.
   localparam int DICT_SIZE = 256;

   // Idling schemes that the random phases walk through.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One row of the directed table. When typed is set, the listed responses
   // are what the block must return. Otherwise the dictionary model decides.
   typedef struct packed {
      lzwc_pkg::req_type req;
      logic              typed;
      logic [1:0]        n_rsp;
      lzwc_pkg::rsp_type rsp0;
      lzwc_pkg::rsp_type rsp1;
   } stim_row_type;

   localparam logic [7:0] CHAR_A = 8'd97;
   localparam logic [7:0] CHAR_B = 8'd98;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   lzwc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   lzwc_pkg::rsp_type rsp_data;

   lzw_text_compressor_core #(
      .DICT_SIZE(DICT_SIZE)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // The dictionary model. Only entries below dict_count are ever searched,
   // and every one of those has been written during the current message.
   logic [7:0]  dict_prefix [DICT_SIZE];
   logic [6:0]  dict_char [DICT_SIZE];
   int unsigned dict_count;
   logic [7:0]  match_code;
   bit          match_active;

   // Codes that the block still owes, oldest first.
   lzwc_pkg::rsp_type pending_codes[$];
   int unsigned       failures;
   int unsigned       requests_sent;
   idle_mode_type     idle_mode;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drops the current message: the dictionary shrinks back to the single
   // characters and no match is pending.
   function automatic void dict_restart();
      dict_count   = lzwc_pkg::BASE_CODES;
      match_code   = '0;
      match_active = 1'b0;
   endfunction

   // Works out the responses that one request causes and advances the
   // dictionary model exactly as the block is expected to.
   function automatic void encode_char(input lzwc_pkg::req_type r,
                                       ref lzwc_pkg::rsp_type codes[$]);
      logic [6:0]  ch;
      int unsigned k;
      bit          found;
      found = 1'b0;
      if (r.character < lzwc_pkg::FIRST_CHAR || r.character > lzwc_pkg::LAST_CHAR) begin
         // A character outside the alphabet is flagged and otherwise ignored,
         // except that a final one still closes the message.
         if (!r.last) begin
            codes.push_back('{code: '0, last_res: 1'b0, error: 1'b1});
         end else if (match_active) begin
            codes.push_back('{code: '0, last_res: 1'b0, error: 1'b1});
            codes.push_back('{code: 9'(match_code) + 9'd1, last_res: 1'b1, error: 1'b0});
            dict_restart();
         end else begin
            codes.push_back('{code: '0, last_res: 1'b1, error: 1'b1});
            dict_restart();
         end
         return;
      end
      ch = 7'(r.character - lzwc_pkg::FIRST_CHAR);
      if (!match_active) begin
         match_code   = 8'(ch);
         match_active = 1'b1;
      end else begin
         for (k = lzwc_pkg::BASE_CODES; k < dict_count && !found; k++) begin
            if (dict_prefix[k] == match_code && dict_char[k] == ch) begin
               found      = 1'b1;
               match_code = 8'(k);
            end
         end
         if (!found) begin
            codes.push_back('{code: 9'(match_code) + 9'd1, last_res: 1'b0, error: 1'b0});
            // Once the dictionary is full it stays frozen until the message ends.
            if (dict_count < DICT_SIZE) begin
               dict_prefix[dict_count] = match_code;
               dict_char[dict_count]   = ch;
               dict_count++;
            end
            match_code = 8'(ch);
         end
      end
      if (r.last) begin
         codes.push_back('{code: 9'(match_code) + 9'd1, last_res: 1'b1, error: 1'b0});
         dict_restart();
      end
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 85;
         IDLE_BOTH:   return $urandom_range(99) < 7;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 85;
         IDLE_BOTH:     return $urandom_range(99) < 7;
         default:       return 1'b0;
      endcase
   endfunction

   // Presents one request and holds it until the block takes it. The request
   // is accepted at the rising edge where valid and ready are both high, and
   // the owed responses are queued right there. For a typed row the table's
   // responses are queued in place of the model's, while the model still
   // advances so that later rows stay in step.
   task automatic send_request(input lzwc_pkg::req_type r, input bit typed,
                               input lzwc_pkg::rsp_type typed_codes[$]);
      lzwc_pkg::rsp_type model_codes[$];
      @(negedge clock);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      encode_char(r, model_codes);
      if (typed) begin
         foreach (typed_codes[i]) pending_codes.push_back(typed_codes[i]);
      end else begin
         foreach (model_codes[i]) pending_codes.push_back(model_codes[i]);
      end
      requests_sent++;
   endtask

   // Stops sending and waits until every owed response has come back.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input logic [7:0] text[$]);
      lzwc_pkg::rsp_type none[$];
      foreach (text[i]) send_request('{character: text[i], last: i == text.size() - 1}, 1'b0, none);
   endtask

   function automatic logic [7:0] noise_char();
      if ($urandom_range(1)) return 8'($urandom_range(lzwc_pkg::FIRST_CHAR - 1));
      return 8'($urandom_range(255, lzwc_pkg::LAST_CHAR + 1));
   endfunction

   function automatic logic [7:0] alphabet_char();
      return 8'($urandom_range(lzwc_pkg::LAST_CHAR, lzwc_pkg::FIRST_CHAR));
   endfunction

   // A message of random length over a few symbols, so that matches grow
   // long, or now and then over the whole alphabet. About one character in
   // twenty is noise, and that includes the closing one at times.
   task automatic send_random_message();
      logic [7:0]  symbols[4];
      logic [7:0]  text[$];
      int unsigned len;
      int unsigned n_sym;
      bit          full_alphabet;
      len           = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
      n_sym         = $urandom_range(4, 1);
      full_alphabet = $urandom_range(3) == 0;
      foreach (symbols[i]) symbols[i] = alphabet_char();
      repeat (len) begin
         if ($urandom_range(19) == 0) text.push_back(noise_char());
         else if (full_alphabet) text.push_back(alphabet_char());
         else text.push_back(symbols[$urandom_range(n_sym - 1)]);
      end
      send_message(text);
   endtask

   // Reports a field that differs from what was owed.
   task automatic report_mismatch(input string field, input int unsigned want, input int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
   endtask

   // The receiving side lowers its ready at random, as the current idling
   // scheme asks. It changes only at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= !receiver_stalls();
   end

   // Every response taken at a rising edge is checked field by field against
   // the oldest owed response.
   always @(posedge clock) begin
      lzwc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            $display("%0t: response with nothing owed, expected none, actual %p", $time,
                     rsp_data);
            failures++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_data.code !== want.code) begin
               report_mismatch("code", want.code, rsp_data.code);
            end
            if (rsp_data.last_res !== want.last_res) begin
               report_mismatch("last_res", want.last_res, rsp_data.last_res);
            end
            if (rsp_data.error !== want.error) begin
               report_mismatch("error", want.error, rsp_data.error);
            end
         end
      end
   end

   // Backstop for a hung block. The slowest correct run, with both sides at
   // their heaviest idling, two responses per request and the clearing pass
   // after every fifteenth message, stays far below this.
   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

   initial begin
      stim_row_type      directed_rows[17];
      lzwc_pkg::rsp_type typed_codes[$];
      logic [7:0]        base_text[$];
      logic [7:0]        long_text[$];

      // Directed requests. Rows with typed responses can be checked by eye:
      // a lone space or 'z' after a fresh start, characters just outside the
      // alphabet on both sides, all-zero and all-one bytes, and a final
      // character with nothing pending. The run of 'a' and 'b' grows the
      // dictionary and then extends a match through a new entry; the noise in
      // its middle must leave the match alone, and the noise that closes it
      // must flush the pending match after the error.
      directed_rows = '{
         '{'{lzwc_pkg::FIRST_CHAR, 1'b1}, 1'b1, 2'd1, '{9'd1, 1'b1, 1'b0}, '0},
         '{'{lzwc_pkg::LAST_CHAR, 1'b1},  1'b1, 2'd1, '{9'd91, 1'b1, 1'b0}, '0},
         '{'{8'd0, 1'b0},       1'b1, 2'd1, '{9'd0, 1'b0, 1'b1}, '0},
         '{'{8'd31, 1'b0},      1'b1, 2'd1, '{9'd0, 1'b0, 1'b1}, '0},
         '{'{8'd123, 1'b0},     1'b1, 2'd1, '{9'd0, 1'b0, 1'b1}, '0},
         '{'{8'd255, 1'b1},     1'b1, 2'd1, '{9'd0, 1'b1, 1'b1}, '0},
         '{'{CHAR_A, 1'b0},     1'b1, 2'd0, '0, '0},
         '{'{CHAR_B, 1'b0},     1'b0, 2'd0, '0, '0},
         '{'{CHAR_A, 1'b0},     1'b0, 2'd0, '0, '0},
         '{'{CHAR_B, 1'b0},     1'b0, 2'd0, '0, '0},
         '{'{CHAR_A, 1'b0},     1'b0, 2'd0, '0, '0},
         '{'{8'd128, 1'b0},     1'b1, 2'd1, '{9'd0, 1'b0, 1'b1}, '0},
         '{'{CHAR_B, 1'b0},     1'b0, 2'd0, '0, '0},
         '{'{8'd200, 1'b1},     1'b0, 2'd0, '0, '0},
         '{'{lzwc_pkg::LAST_CHAR, 1'b0},  1'b1, 2'd0, '0, '0},
         '{'{lzwc_pkg::LAST_CHAR, 1'b1},  1'b0, 2'd0, '0, '0},
         '{'{CHAR_A, 1'b1},     1'b1, 2'd1, '{9'd66, 1'b1, 1'b0}, '0}
      };

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      failures      = 0;
      requests_sent = 0;
      idle_mode     = IDLE_NONE;
      dict_restart();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_codes.delete();
         if (directed_rows[i].n_rsp > 0) typed_codes.push_back(directed_rows[i].rsp0);
         if (directed_rows[i].n_rsp > 1) typed_codes.push_back(directed_rows[i].rsp1);
         send_request(directed_rows[i].req, directed_rows[i].typed, typed_codes);
      end

      // A long message that fills the dictionary: a random text over the
      // whole alphabet, sent twice so that the second pass extends matches
      // through the entries near the top and keeps going once no room is left.
      repeat (168) base_text.push_back(alphabet_char());
      long_text = {base_text, base_text};
      send_message(long_text);

      // Random messages under each idling scheme in turn. At the end of every
      // phase the sender holds off until all owed responses are back.
      for (int phase = 0; phase < 4; phase++) begin
         idle_mode = idle_mode_type'(phase);
         while (requests_sent < 353 + 125 * (phase + 1)) send_random_message();
         drain_responses();
      end

      // Leave room for a stray response before the verdict.
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/lzwc_pkg.sv
rtl/lzwc_dict_mem.sv
rtl/lzwc_rsp_queue.sv
rtl/lzw_text_compressor_core.sv
dv/tb_top.sv
